### hdl/fircu_pkg.sv
// fircu_pkg: shared sizes, register indexes and types of the FIR full convolution unit.
// No dependencies. Used by fircu_cell, fircu_sum_round, fir_full_convolution_unit and its testbench.
`default_nettype none

package fircu_pkg;

	localparam int TAPS       = 7;
	localparam int DATA_WIDTH = 16;

	localparam int FRAC_BITS  = DATA_WIDTH - 1;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int SUM_W      = PROD_W + $clog2(TAPS);
	localparam int QUOT_W     = SUM_W - FRAC_BITS;
	localparam int CNT_W      = $clog2(TAPS + 1);
	localparam int CFG_IDX_W  = $clog2(TAPS + 1);
	localparam int TC_W       = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = CFG_IDX_W'(1);

	typedef logic signed [DATA_WIDTH-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef prod_t [TAPS-1:0]             prod_vec_t;

	// per-cycle control of every cell in the chain
	typedef struct packed {
		logic adv;
		logic clr;
	} cell_ctl_t;

	// control that travels along the pipeline beside the data
	typedef struct packed {
		logic vld;
		logic last;
	} pipe_ctl_t;

endpackage

`default_nettype wire

### hdl/fircu_cell.sv
// fircu_cell: one tap of the chain: coefficient, delay-line entry and registered product.
// Depends on fircu_pkg.
`default_nettype none

module fircu_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     coef_we,
	input  fircu_pkg::sample_t      coef_wdata,
	input  fircu_pkg::cell_ctl_t    ctl,
	input  wire                     act,
	input  fircu_pkg::sample_t      tap_in,
	output fircu_pkg::sample_t      tap_out,
	output fircu_pkg::prod_t        prod_s1
);

	fircu_pkg::sample_t coef_q;
	fircu_pkg::sample_t tap_q;
	fircu_pkg::prod_t   mul;

	assign mul     = fircu_pkg::PROD_W'(coef_q) * fircu_pkg::PROD_W'(tap_in);
	assign tap_out = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			tap_q  <= '0;
		end else begin
			if (coef_we) begin
				coef_q <= coef_wdata;
			end
			// shift the new value on, or drop the whole line at end of block
			if (ctl.adv) begin
				tap_q <= ctl.clr ? '0 : tap_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s1 <= act ? mul : '0;
		end
	end

endmodule

`default_nettype wire

### hdl/fircu_sum_round.sv
// fircu_sum_round: exact sum of the tap products, then rounding and saturation to Q1.15.
// Depends on fircu_pkg. Holds pipeline stages s2 (sum) and s3 (output register).
`default_nettype none

module fircu_sum_round (
	input  wire                     clk,
	input  wire                     arst_n,
	input  fircu_pkg::pipe_ctl_t    ctl_s1,
	input  fircu_pkg::prod_vec_t    prod_s1,
	output logic                    s1_ready,
	input  wire                     out_ready,
	output fircu_pkg::pipe_ctl_t    ctl_out,
	output fircu_pkg::sample_t      filtered,
	output logic                    saturated
);

	localparam int DW = fircu_pkg::DATA_WIDTH;
	localparam int QW = fircu_pkg::QUOT_W;

	fircu_pkg::pipe_ctl_t              ctl_s2;
	fircu_pkg::pipe_ctl_t              ctl_s3;
	logic signed [fircu_pkg::SUM_W-1:0] sum_s2;
	logic signed [fircu_pkg::SUM_W-1:0] acc;
	logic signed [fircu_pkg::SUM_W-1:0] rnd;
	logic signed [QW-1:0]              quot;
	logic                              sat_hi;
	logic                              sat_lo;
	logic                              en2;
	logic                              en3;
	fircu_pkg::sample_t                filtered_s3;
	logic                              sat_s3;

	assign en3      = !ctl_s3.vld || out_ready;
	assign en2      = !ctl_s2.vld || en3;
	assign s1_ready = en2;

	always_comb begin
		acc = '0;
		for (int i = 0; i < fircu_pkg::TAPS; i++) begin
			acc = acc + fircu_pkg::SUM_W'(prod_s1[i]);
		end
	end

	// add one half LSB, floor, then clip to the sample range
	assign rnd    = sum_s2 + (fircu_pkg::SUM_W'(1) <<< (fircu_pkg::FRAC_BITS - 1));
	assign quot   = QW'(rnd >>> fircu_pkg::FRAC_BITS);
	assign sat_hi = !quot[QW-1] && (|quot[QW-2:DW-1]);
	assign sat_lo = quot[QW-1] && !(&quot[QW-2:DW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (en2) begin
				ctl_s2 <= ctl_s1;
			end
			if (en3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sum_s2 <= acc;
		end
		if (en3) begin
			sat_s3 <= sat_hi || sat_lo;
			if (sat_hi) begin
				filtered_s3 <= {1'b0, {(DW-1){1'b1}}};
			end else if (sat_lo) begin
				filtered_s3 <= {1'b1, {(DW-1){1'b0}}};
			end else begin
				filtered_s3 <= quot[DW-1:0];
			end
		end
	end

	assign ctl_out   = ctl_s3;
	assign filtered  = filtered_s3;
	assign saturated = sat_s3;

endmodule

`default_nettype wire

### hdl/fir_full_convolution_unit.sv
// fir_full_convolution_unit: top level of the FIR full convolution unit.
// Depends on fircu_pkg, fircu_cell and fircu_sum_round.
//
// Channel  Direction  Handshake              Payload
// s_*      in         s_tvalid / s_tready    tdata = sample, tlast = end_of_block
// m_*      out        m_tvalid / m_tready    tdata = filtered, tuser = saturated,
//                                            tlast = final_output
// cfg_*    in         cfg_valid / cfg_ready  cfg_index = register, cfg_data = value
//
// Rate: one sample per clock while no tail runs and m_tready does not stall. A
// sample with tlast set is followed by M-1 tail steps (M = active tap count) in
// which the chain shifts in zeros and s_tready is low; so a block of N samples
// gives N+M-1 outputs. Pipeline stages: products (s1), sum (s2), rounded output
// register (s3). Reset clears the delay line and coefficients and sets M to one;
// cfg_ready is always high. A stall on m_tready fills the free pipeline stages
// first, then holds s_tready low; no item is lost or repeated.
`default_nettype none

module fir_full_convolution_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// slave stream: [15:0] sample
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [fircu_pkg::DATA_WIDTH-1:0]     s_tdata,
	input  wire                                  s_tlast,
	// master stream: [15:0] filtered
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [fircu_pkg::DATA_WIDTH-1:0]     m_tdata,
	// m_tuser: [0] saturated
	output logic                                 m_tuser,
	output logic                                 m_tlast,
	// configuration write channel
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [fircu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [fircu_pkg::DATA_WIDTH-1:0]     cfg_data
);

	localparam int TAPS  = fircu_pkg::TAPS;
	localparam int CNT_W = fircu_pkg::CNT_W;

	logic [fircu_pkg::TC_W-1:0] tap_count_q;
	logic [CNT_W-1:0]           m_act;
	logic [CNT_W-1:0]           tail_cnt_q;
	logic                       tail_act_q;
	logic                       cfg_wr;
	logic [TAPS-1:0]            coef_we;

	logic                       en1;
	logic                       s1_ready;
	logic                       in_acc;
	logic                       tail_step;
	logic                       tail_last;
	logic                       single_tap;
	logic                       adv_last;

	fircu_pkg::cell_ctl_t       cell_ctl;
	fircu_pkg::pipe_ctl_t       ctl_s1;
	fircu_pkg::pipe_ctl_t       ctl_out;
	fircu_pkg::prod_vec_t       prod_s1;
	fircu_pkg::sample_t         tap_chain [TAPS];
	fircu_pkg::sample_t         filtered;
	logic                       saturated;

	// ---------------------------------------------------------------
	// configuration: always ready, writes beyond the list are dropped
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			coef_we[i] = cfg_wr &&
				(cfg_index == fircu_pkg::REG_COEF_BASE + fircu_pkg::CFG_IDX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fircu_pkg::TC_W'(1);
		end else if (cfg_wr && cfg_index == fircu_pkg::REG_TAP_COUNT) begin
			tap_count_q <= cfg_data[fircu_pkg::TC_W-1:0];
		end
	end

	// clamp the tap count: zero acts as one, above TAPS acts as TAPS
	always_comb begin
		if (tap_count_q == '0) begin
			m_act = CNT_W'(1);
		end else if (int'(tap_count_q) > TAPS) begin
			m_act = CNT_W'(TAPS);
		end else begin
			m_act = CNT_W'(tap_count_q);
		end
	end

	// ---------------------------------------------------------------
	// input acceptance and tail sequencing
	// ---------------------------------------------------------------
	assign en1        = !ctl_s1.vld || s1_ready;
	assign s_tready   = en1 && !tail_act_q;
	assign in_acc     = s_tvalid && s_tready;
	assign tail_step  = tail_act_q && en1;
	assign single_tap = (m_act == CNT_W'(1));
	assign tail_last  = (tail_cnt_q == m_act - CNT_W'(1));

	// last output of a block: end-of-block sample with one tap, or the final tail step
	assign adv_last     = (in_acc && s_tlast && single_tap) || (tail_step && tail_last);
	assign cell_ctl.adv = in_acc || tail_step;
	assign cell_ctl.clr = adv_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_act_q <= 1'b0;
			tail_cnt_q <= '0;
			ctl_s1     <= '0;
		end else begin
			if (in_acc && s_tlast && !single_tap) begin
				tail_act_q <= 1'b1;
				tail_cnt_q <= CNT_W'(1);
			end else if (tail_step) begin
				if (tail_last) begin
					tail_act_q <= 1'b0;
					tail_cnt_q <= '0;
				end else begin
					tail_cnt_q <= tail_cnt_q + CNT_W'(1);
				end
			end
			if (en1) begin
				ctl_s1.vld  <= cell_ctl.adv;
				ctl_s1.last <= adv_last;
			end
		end
	end

	// tail steps feed zeros into the head of the chain
	assign tap_chain[0] = in_acc ? fircu_pkg::sample_t'(s_tdata) : '0;

	// ---------------------------------------------------------------
	// chain of tap cells
	// ---------------------------------------------------------------
	for (genvar g = 0; g < TAPS; g++) begin : g_cell
		if (g < TAPS - 1) begin : g_mid
			fircu_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.coef_we    (coef_we[g]),
				.coef_wdata (fircu_pkg::sample_t'(cfg_data)),
				.ctl        (cell_ctl),
				.act        (CNT_W'(g) < m_act),
				.tap_in     (tap_chain[g]),
				.tap_out    (tap_chain[g+1]),
				.prod_s1    (prod_s1[g])
			);
		end else begin : g_end
			fircu_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.coef_we    (coef_we[g]),
				.coef_wdata (fircu_pkg::sample_t'(cfg_data)),
				.ctl        (cell_ctl),
				.act        (CNT_W'(g) < m_act),
				.tap_in     (tap_chain[g]),
				.tap_out    (),
				.prod_s1    (prod_s1[g])
			);
		end
	end

	// ---------------------------------------------------------------
	// sum, round, saturate and output register
	// ---------------------------------------------------------------
	fircu_sum_round u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.prod_s1   (prod_s1),
		.s1_ready  (s1_ready),
		.out_ready (m_tready),
		.ctl_out   (ctl_out),
		.filtered  (filtered),
		.saturated (saturated)
	);

	assign m_tvalid = ctl_out.vld;
	assign m_tlast  = ctl_out.last;
	assign m_tdata  = filtered;
	assign m_tuser  = saturated;

`ifndef ASSERT_OFF
	// input stays closed for the whole tail
	a_no_input_in_tail: assert property (@(posedge clk) disable iff (!arst_n)
		tail_act_q |-> !s_tready)
		else $error("input accepted during tail flush");

	// a multi-tap end of block starts the tail
	a_tail_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tlast && !single_tap) |=> tail_act_q)
		else $error("tail did not start after end of block");

	// the tail counter stays within 1 .. M-1
	a_tail_range: assert property (@(posedge clk) disable iff (!arst_n)
		tail_act_q |-> (tail_cnt_q != '0 && tail_cnt_q < m_act))
		else $error("tail counter out of range");

	// the first delay-line entry is empty after the last output of a block
	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_last |=> (tap_chain[1] == '0))
		else $error("delay line not cleared at end of block");
`endif

endmodule

`default_nettype wire

### verif/tb_fir_full_convolution_unit.sv
`timescale 1ns / 100ps
// tb_fir_full_convolution_unit: self-checking testbench of the FIR full convolution unit.
// Runs a directed table, then random sample blocks under random tap settings.
// Depends on fircu_pkg and fir_full_convolution_unit.

module tb_fir_full_convolution_unit;

	import fircu_pkg::*;

	localparam int CLK_HIGH      = 10;
	localparam int CLK_LOW       = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int STALL_LIMIT   = 1000;  // cycles with no handshake on any channel
	localparam int DRAIN_CYCLES  = 8;     // cycles to watch past the three-stage pipeline for stray outputs
	localparam int RANDOM_ITEMS  = 348;
	localparam int MAX_REPORTS   = 10;
	localparam int KEEP_SETTING  = -1;
	localparam int DIR_SETTINGS  = 7;
	localparam int DIR_ROWS      = 22;

	localparam longint Q_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint Q_MIN = -Q_MAX - 1;

	// one output item of the master stream
	typedef struct packed {
		sample_t filtered;
		logic    saturated;
		logic    final_output;
	} fir_out_t;

	// a full register set: tap count plus every coefficient
	typedef struct packed {
		logic [TC_W-1:0]       taps;
		sample_t [0:TAPS-1]    coef;
	} fir_setting_t;

	// directed row: optional retune before the item, and a typed-in output where
	// the value is obvious (one result only)
	typedef struct packed {
		int       setting;
		sample_t  sample;
		logic     eob;
		logic     typed;
		fir_out_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [DATA_WIDTH-1:0]  s_tdata;   // [15:0] sample
	logic                   s_tlast;   // end_of_block
	logic                   m_tvalid;
	logic                   m_tready;
	logic [DATA_WIDTH-1:0]  m_tdata;   // [15:0] filtered
	logic                   m_tuser;   // [0] saturated
	logic                   m_tlast;   // final_output
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DATA_WIDTH-1:0]  cfg_data;

	// convolution model: its own register copy and delay line
	logic [TC_W-1:0]  tap_cfg;
	sample_t          coef_cfg [TAPS];
	sample_t          history [TAPS];
	fir_out_t         pending_outputs [$];

	fir_setting_t     dir_settings [DIR_SETTINGS];
	dir_row_t         dir_rows [DIR_ROWS];

	int src_gap_pct;
	int sink_gap_pct;
	int stall_count;
	int mismatches;
	int items_sent;
	int outputs_checked;
	int blocks_sent;
	int settings_applied;

	fir_full_convolution_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#CLK_HIGH;
		clk = 1'b0;
		#CLK_LOW;
	end

	// ------------------------------------------------------------------
	// Convolution model
	// ------------------------------------------------------------------

	function automatic void shift_history(input sample_t x);
		for (int i = TAPS - 1; i > 0; i--)
			history[i] = history[i - 1];
		history[0] = x;
	endfunction

	// Exact sum of products, round half up to Q1.15, then clip to range.
	function automatic fir_out_t filter_output(input int m, input logic last_out);
		longint   acc;
		fir_out_t r;
		acc = 0;
		for (int i = 0; i < m; i++)
			acc += longint'(coef_cfg[i]) * longint'(history[i]);
		acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		r.saturated    = 1'b1;
		r.final_output = last_out;
		if (acc > Q_MAX)
			r.filtered = sample_t'(Q_MAX);
		else if (acc < Q_MIN)
			r.filtered = sample_t'(Q_MIN);
		else begin
			r.filtered  = sample_t'(acc);
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	// Queue every output one accepted sample causes: its own, plus the zero-fed
	// tail on end of block, after which the delay line starts over.
	function automatic void convolve_sample(input sample_t x, input logic eob);
		int m;
		// a tap count of zero acts as one; the 3-bit field cannot exceed TAPS
		m = (tap_cfg == '0) ? 1 : ((int'(tap_cfg) > TAPS) ? TAPS : int'(tap_cfg));
		shift_history(x);
		pending_outputs.push_back(filter_output(m, eob && m == 1));
		if (eob) begin
			for (int t = 1; t < m; t++) begin
				shift_history('0);
				pending_outputs.push_back(filter_output(m, t == m - 1));
			end
			foreach (history[i])
				history[i] = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly full range, with extremes and small values mixed in.
	function automatic sample_t random_q15();
		case ($urandom_range(9))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2, 3:    return sample_t'($urandom_range(4095) - 2048);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic fir_setting_t random_setting();
		fir_setting_t s;
		if ($urandom_range(3) == 0)
			s.taps = $urandom_range(1) ? TC_W'(TAPS) : TC_W'(1);
		else
			s.taps = TC_W'($urandom_range(7));
		for (int k = 0; k < TAPS; k++)
			s.coef[k] = random_q15();
		return s;
	endfunction

	// Drive one item; hold it until the slave side takes it, then predict.
	task automatic send_sample(input sample_t x, input logic eob);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		s_tlast  <= eob;
		do @(posedge clk); while (!s_tready);
		convolve_sample(x, eob);
		items_sent++;
	endtask

	// Leaves cfg_valid high so back-to-back writes never drop it in between.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TAP_COUNT)
			tap_cfg = value[TC_W-1:0];
		else
			coef_cfg[idx - REG_COEF_BASE] = value;
	endtask

	// Pause the sender until every pending output is out, then rewrite all
	// registers. A block may be half done here: its delay line carries over.
	task automatic retune(input fir_setting_t s);
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		write_reg(REG_TAP_COUNT, DATA_WIDTH'(s.taps));
		for (int k = 0; k < TAPS; k++)
			write_reg(REG_COEF_BASE + CFG_IDX_W'(k), s.coef[k]);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure and in-order checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin : sink
		fir_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0)
				flag_mismatch($sformatf("output %h sat %b last %b with nothing pending",
					m_tdata, m_tuser, m_tlast));
			else begin
				want = pending_outputs.pop_front();
				if (m_tdata !== want.filtered || m_tuser !== want.saturated
						|| m_tlast !== want.final_output)
					flag_mismatch($sformatf(
						"output %0d: got %h sat %b last %b, want %h sat %b last %b",
						outputs_checked, m_tdata, m_tuser, m_tlast,
						want.filtered, want.saturated, want.final_output));
				outputs_checked++;
			end
		end
		m_tready <= ($urandom_range(99) >= sink_gap_pct);
	end

	// Stop a hung run: count cycles in which no channel moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d outputs pending",
				stall_count, pending_outputs.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		stall_count      = 0;
		mismatches       = 0;
		items_sent       = 0;
		outputs_checked  = 0;
		blocks_sent      = 0;
		settings_applied = 0;

		// model state after reset
		tap_cfg = TC_W'(1);
		foreach (coef_cfg[i])
			coef_cfg[i] = '0;
		foreach (history[i])
			history[i] = '0;

		dir_settings = '{
			'{3'd1, '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
			'{3'd0, '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
			'{3'd7, '{TAPS{16'h7fff}}},
			'{3'd7, '{TAPS{16'h8000}}},
			'{3'd3, '{16'h2000, 16'hc000, 16'h1234, 16'h0fff, 16'hffff, 16'h0001, 16'hcfc7}},
			'{3'd5, '{16'h2000, 16'hc000, 16'h1234, 16'h0fff, 16'hffff, 16'h0001, 16'hcfc7}},
			'{3'd2, '{16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}}
		};

		// setting, sample, end of block, typed, typed output {filtered, sat, last}
		dir_rows = '{
			// reset values: one tap, zero coefficient, so every output is zero
			'{KEEP_SETTING, 16'h7fff, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
			// single tap: the end-of-block output itself is the last one
			'{KEEP_SETTING, 16'h8000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
			// coefficient -1: -1 * -1 overflows and clips
			'{0,            16'h8000, 1'b0, 1'b1, '{16'h7fff, 1'b1, 1'b0}},
			'{KEEP_SETTING, 16'h7fff, 1'b0, 1'b1, '{16'h8001, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h8000, 1'b1, 1'b1, '{16'h7fff, 1'b1, 1'b1}},
			// tap count zero behaves as one; coefficient one half shows ties rounding up
			'{1,            16'h0001, 1'b0, 1'b1, '{16'h0001, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'hffff, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h0003, 1'b1, 1'b1, '{16'h0002, 1'b0, 1'b1}},
			// all taps at full scale: large positive sums clip, tail drains six outputs
			'{2,            16'h7fff, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h7fff, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h7fff, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h8000, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			// all taps at -1
			'{3,            16'h8000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h8000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h7fff, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			// tap count grows from three to five in the middle of a block
			'{4,            16'h1000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'ha5a5, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{5,            16'h5a5a, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			'{KEEP_SETTING, 16'h7ffe, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
			// one-sample block with a tail
			'{6,            16'h4321, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}}
		};

		src_gap_pct  = 26;
		sink_gap_pct = 45;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (dir_rows[r]) begin
			if (dir_rows[r].setting != KEEP_SETTING)
				retune(dir_settings[dir_rows[r].setting]);
			send_sample(dir_rows[r].sample, dir_rows[r].eob);
			if (dir_rows[r].eob)
				blocks_sent++;
			// typed rows cause exactly one output: take the table value for it
			if (dir_rows[r].typed)
				pending_outputs[pending_outputs.size() - 1] = dir_rows[r].want;
		end

		// random part in three idle profiles: receiver-heavy gaps, sender-heavy
		// gaps, then full throughput
		for (int ph = 0; ph < 3; ph++) begin : rand_phase
			int target;
			int blk_len;
			src_gap_pct  = (ph == 0) ? 26 : ((ph == 1) ? 45 : 0);
			sink_gap_pct = (ph == 0) ? 45 : ((ph == 1) ? 26 : 0);
			target = items_sent + RANDOM_ITEMS / 3;
			retune(random_setting());
			while (items_sent < target) begin
				if ($urandom_range(2) == 0)
					retune(random_setting());
				// mostly short blocks, now and then a long one
				blk_len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(8, 1);
				for (int j = 0; j < blk_len; j++) begin
					// occasionally change taps while a block is still open
					if (j > 0 && $urandom_range(15) == 0)
						retune(random_setting());
					send_sample(random_q15(), j == blk_len - 1);
				end
				blocks_sent++;
			end
		end

		// drop valid, collect what is left, then watch for stray outputs
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples in %0d blocks under %0d register settings",
			items_sent, blocks_sent, settings_applied);
		$display("%0d outputs checked, %0d mismatches", outputs_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### fir_full_convolution_unit.f
hdl/fircu_pkg.sv
hdl/fircu_cell.sv
hdl/fircu_sum_round.sv
hdl/fir_full_convolution_unit.sv
verif/tb_fir_full_convolution_unit.sv
